// ===== src/jacobi_five_point_sweep_macros.svh =====
// Assertion macros for the five-point Jacobi sweep block.
// Depends on nothing; included by jacobi_five_point_sweep.sv, which carries the concurrent checks.
`ifndef JACOBI_FIVE_POINT_SWEEP_MACROS_SVH
`define JACOBI_FIVE_POINT_SWEEP_MACROS_SVH

// Consequent checked in the same cycle as the antecedent.
`define JFPS_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define JFPS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/jfps_pkg.sv =====
// Shared types and constants for the five-point Jacobi sweep block.
// Depends on nothing; used by every module of the block.
package jfps_pkg;

  localparam int MAX_LINE_DEFAULT   = 4096;
  localparam int DATA_WIDTH_DEFAULT = 32;

  localparam int SIZE_W     = 12;
  localparam int HALO_W     = 4;
  localparam int POS_OUT_W  = 12;
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W = 12;

  localparam logic [SIZE_W-1:0] RESET_INTERIOR = 12'd2048;
  localparam logic [HALO_W-1:0] RESET_HALO     = 4'd2;

  localparam int QUEUE_DEPTH = 3;
  localparam int QPTR_W      = 2;
  localparam int QCNT_W      = 2;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_INTERIOR_SIZE = 2'd0,
    REG_HALO_WIDTH    = 2'd1
  } cfg_reg_e;

  typedef struct packed {
    logic                 emit;
    logic [POS_OUT_W-1:0] row;
    logic [POS_OUT_W-1:0] col;
    logic                 frame_end;
  } stencil_tag_t;

endpackage

// ===== src/jfps_raster.sv =====
// Configuration registers, raster position counters and interior decode.
// Depends on jfps_pkg.
module jfps_raster import jfps_pkg::*; #(
  parameter int MAX_LINE = MAX_LINE_DEFAULT
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [CFG_INDEX_W-1:0]        cfg_index,
  input  logic [CFG_DATA_W-1:0]         cfg_data,
  input  logic                          advance,
  output logic                          active,
  output logic [$clog2(MAX_LINE)-1:0]   row_pos,
  output stencil_tag_t                  tag
);

  localparam int POS_W = $clog2(MAX_LINE);
  localparam int CMP_W = (POS_W + 1 > SIZE_W + 1) ? POS_W + 1 : SIZE_W + 1;

  function automatic logic [CMP_W-1:0] side_of(input logic [SIZE_W-1:0] n,
                                               input logic [HALO_W-1:0] h);
    logic [CMP_W-1:0] raw;
    raw = CMP_W'(n) + (CMP_W'(h) << 1);
    return (raw > CMP_W'(MAX_LINE)) ? CMP_W'(MAX_LINE) : raw;
  endfunction

  logic [SIZE_W-1:0] interior, interior_next;
  logic [HALO_W-1:0] halo, halo_next;
  logic [CMP_W-1:0]  side, side_next;
  logic [CMP_W-1:0]  hn, hn_next;
  logic [CMP_W-1:0]  hn_last, hn_last_next;
  logic [POS_W-1:0]  col_pos;
  logic [POS_W-1:0]  row_pos_next, col_pos_next;
  logic [CMP_W-1:0]  rc, cc, cm1, row_step, col_step, halo_c;

  always_comb begin
    interior_next = interior;
    halo_next     = halo;
    if (cfg_we) begin
      unique case (cfg_reg_e'(cfg_index))
        REG_INTERIOR_SIZE: interior_next = cfg_data[SIZE_W-1:0];
        REG_HALO_WIDTH:    halo_next     = cfg_data[HALO_W-1:0];
        default: ;
      endcase
    end
    side_next    = side_of(interior_next, halo_next);
    hn_next      = CMP_W'(interior_next) + CMP_W'(halo_next);
    hn_last_next = hn_next - 1'b1;
  end

  always_comb begin
    rc       = CMP_W'(row_pos);
    cc       = CMP_W'(col_pos);
    cm1      = cc - 1'b1;
    row_step = rc + 1'b1;
    col_step = cc + 1'b1;
    halo_c   = CMP_W'(halo);

    row_pos_next = row_pos;
    col_pos_next = col_pos;
    priority if (cfg_we) begin
      row_pos_next = '0;
      col_pos_next = '0;
    end else if (advance) begin
      if (row_step >= side) begin
        row_pos_next = '0;
        col_pos_next = (col_step >= side) ? '0 : col_pos + 1'b1;
      end else begin
        row_pos_next = row_pos + 1'b1;
      end
    end else begin
      row_pos_next = row_pos;
      col_pos_next = col_pos;
    end

    tag.emit      = (cc >= CMP_W'(2)) && (rc >= CMP_W'(1)) && (row_step < side) &&
                    (cm1 >= halo_c) && (cm1 < hn) && (rc >= halo_c) && (rc < hn);
    tag.row       = POS_OUT_W'(rc - halo_c);
    tag.col       = POS_OUT_W'(cm1 - halo_c);
    tag.frame_end = (rc == hn_last) && (cm1 == hn_last);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      interior <= RESET_INTERIOR;
      halo     <= RESET_HALO;
      side     <= side_of(RESET_INTERIOR, RESET_HALO);
      hn       <= CMP_W'(RESET_INTERIOR) + CMP_W'(RESET_HALO);
      hn_last  <= CMP_W'(RESET_INTERIOR) + CMP_W'(RESET_HALO) - 1'b1;
      row_pos  <= '0;
      col_pos  <= '0;
    end else begin
      interior <= interior_next;
      halo     <= halo_next;
      side     <= side_next;
      hn       <= hn_next;
      hn_last  <= hn_last_next;
      row_pos  <= row_pos_next;
      col_pos  <= col_pos_next;
    end
  end

  assign active = (side != '0);

endmodule

// ===== src/jfps_col_store.sv =====
// Two column memories with registered reads and forwarding of the
// write in flight. Depends on jfps_pkg.
module jfps_col_store import jfps_pkg::*; #(
  parameter int DATA_WIDTH = DATA_WIDTH_DEFAULT,
  parameter int MAX_LINE   = MAX_LINE_DEFAULT
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          rd_en,
  input  logic [$clog2(MAX_LINE)-1:0]   rd_addr,
  input  logic                          wr_en,
  input  logic [$clog2(MAX_LINE)-1:0]   wr_addr,
  input  logic [DATA_WIDTH-1:0]         wr_x,
  output logic [DATA_WIDTH-1:0]         up,
  output logic [DATA_WIDTH-1:0]         down,
  output logic [DATA_WIDTH-1:0]         left
);

  localparam int ADDR_W = $clog2(MAX_LINE);

  logic [DATA_WIDTH-1:0] col_before [MAX_LINE];
  logic [DATA_WIDTH-1:0] col_centre [MAX_LINE];

  logic [DATA_WIDTH-1:0] rd_b, rd_c0, rd_c1;
  logic [DATA_WIDTH-1:0] fwd_b_val, fwd_x_val, up_q;
  logic                  fwd_b, fwd_c0, fwd_c1;
  logic [DATA_WIDTH-1:0] centre_old;
  logic [ADDR_W-1:0]     nbr_addr;

  assign nbr_addr   = rd_addr + 1'b1;
  assign centre_old = fwd_c0 ? fwd_x_val : rd_c0;
  assign left       = fwd_b ? fwd_b_val : rd_b;
  assign down       = fwd_c1 ? fwd_x_val : rd_c1;
  assign up         = up_q;

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_b      <= col_before[rd_addr];
      rd_c0     <= col_centre[rd_addr];
      rd_c1     <= col_centre[nbr_addr];
      fwd_b_val <= centre_old;
      fwd_x_val <= wr_x;
    end
    if (wr_en) begin
      col_before[wr_addr] <= centre_old;
      col_centre[wr_addr] <= wr_x;
      up_q                <= centre_old;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fwd_b  <= 1'b0;
      fwd_c0 <= 1'b0;
      fwd_c1 <= 1'b0;
    end else if (rd_en) begin
      fwd_b  <= wr_en && (rd_addr == wr_addr);
      fwd_c0 <= wr_en && (rd_addr == wr_addr);
      fwd_c1 <= wr_en && (nbr_addr == wr_addr);
    end
  end

endmodule

// ===== src/jfps_out_queue.sv =====
// Small result queue that parts the stencil stage from the output stall.
// Depends on jfps_pkg.
module jfps_out_queue import jfps_pkg::*; #(
  parameter int WIDTH = DATA_WIDTH_DEFAULT
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  logic [WIDTH-1:0]  push_data,
  output logic              valid,
  input  logic              stall,
  output logic [WIDTH-1:0]  data,
  output logic [QCNT_W-1:0] count
);

  function automatic logic [QPTR_W-1:0] ptr_inc(input logic [QPTR_W-1:0] p);
    return (p == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  logic [WIDTH-1:0]  slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0] rd_ptr, wr_ptr;
  logic              pop;

  assign valid = (count != '0);
  assign pop   = valid && !stall;
  assign data  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ptr <= '0;
      wr_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= ptr_inc(wr_ptr);
      end
      if (pop) begin
        rd_ptr <= ptr_inc(rd_ptr);
      end
      unique case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

// ===== src/jacobi_five_point_sweep.sv =====
// Top level of the five-point Jacobi sweep; uses jfps_pkg, jfps_raster,
// jfps_col_store and jfps_out_queue. One cell per cycle sustained while result_stall
// is low. Path: memory read, then sum into a three-entry queue; a result is offered
// once its sum is registered in the queue. Input stalls while three items wait.
// Reset clears control state, restores interior_size 2048 and halo_width 2;
// column memories are not cleared.
`include "jacobi_five_point_sweep_macros.svh"

module jacobi_five_point_sweep import jfps_pkg::*; #(
  parameter int MAX_LINE   = MAX_LINE_DEFAULT,
  parameter int DATA_WIDTH = DATA_WIDTH_DEFAULT
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [CFG_INDEX_W-1:0]       cfg_index,
  input  logic [CFG_DATA_W-1:0]        cfg_data,
  input  logic                         cell_valid,
  output logic                         cell_stall,
  input  logic signed [DATA_WIDTH-1:0] cell_value,
  output logic                         result_valid,
  input  logic                         result_stall,
  output logic signed [DATA_WIDTH-1:0] new_value,
  output logic [POS_OUT_W-1:0]         out_row,
  output logic [POS_OUT_W-1:0]         out_col,
  output logic                         frame_end
);

  localparam int ADDR_W    = $clog2(MAX_LINE);
  localparam int SUM_W     = DATA_WIDTH + 2;
  localparam int PAYLOAD_W = DATA_WIDTH + 2 * POS_OUT_W + 1;

  logic                  cfg_we, active, launch, push;
  logic [ADDR_W-1:0]     row_pos, s1_row;
  stencil_tag_t          tag, s1_tag;
  logic                  s1_valid;
  logic [DATA_WIDTH-1:0] s1_x;
  logic [DATA_WIDTH-1:0] up, down, left;
  logic [SUM_W-1:0]      sum;
  logic [QCNT_W-1:0]     q_count;
  logic [QCNT_W:0]       occupancy;
  logic [PAYLOAD_W-1:0]  push_data, q_data;

  assign cfg_ready = 1'b1;
  assign cfg_we    = cfg_valid && cfg_ready;

  assign occupancy  = {1'b0, q_count} + {{QCNT_W{1'b0}}, s1_valid};
  assign cell_stall = (occupancy >= (QCNT_W + 1)'(QUEUE_DEPTH));
  assign launch     = cell_valid && !cell_stall && active;

  jfps_raster #(
    .MAX_LINE (MAX_LINE)
  ) u_raster (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .advance   (launch),
    .active    (active),
    .row_pos   (row_pos),
    .tag       (tag)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= launch;
    end
  end

  always_ff @(posedge clk) begin
    if (launch) begin
      s1_x   <= cell_value;
      s1_tag <= tag;
      s1_row <= row_pos;
    end
  end

  jfps_col_store #(
    .DATA_WIDTH (DATA_WIDTH),
    .MAX_LINE   (MAX_LINE)
  ) u_col_store (
    .clk     (clk),
    .rst     (rst),
    .rd_en   (launch),
    .rd_addr (row_pos),
    .wr_en   (s1_valid),
    .wr_addr (s1_row),
    .wr_x    (s1_x),
    .up      (up),
    .down    (down),
    .left    (left)
  );

  assign sum = {{2{up[DATA_WIDTH-1]}}, up} + {{2{down[DATA_WIDTH-1]}}, down} +
               {{2{left[DATA_WIDTH-1]}}, left} + {{2{s1_x[DATA_WIDTH-1]}}, s1_x};

  assign push      = s1_valid && s1_tag.emit;
  assign push_data = {sum[SUM_W-1:2], s1_tag.row, s1_tag.col, s1_tag.frame_end};

  jfps_out_queue #(
    .WIDTH (PAYLOAD_W)
  ) u_out_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .valid     (result_valid),
    .stall     (result_stall),
    .data      (q_data),
    .count     (q_count)
  );

  assign new_value = q_data[PAYLOAD_W-1 -: DATA_WIDTH];
  assign out_row   = q_data[2*POS_OUT_W -: POS_OUT_W];
  assign out_col   = q_data[POS_OUT_W -: POS_OUT_W];
  assign frame_end = q_data[0];

  `JFPS_ASSERT_NOW(a_queue_room, clk, rst, push, q_count < QCNT_W'(QUEUE_DEPTH), "queue overflow")
  `JFPS_ASSERT_NOW(a_frame_end_corner, clk, rst, result_valid && frame_end, out_row == out_col, "frame end off the corner")
  `JFPS_ASSERT_NOW(a_row_sequence, clk, rst, s1_valid && $past(s1_valid) && s1_row != '0, s1_row == ADDR_W'($past(s1_row) + 1'b1), "rows out of raster order")
  `JFPS_ASSERT_NEXT(a_frame_end_out, clk, rst, push && s1_tag.frame_end, result_valid, "last cell result lost")

endmodule

// ===== tb/jacobi_five_point_sweep_test.sv =====
// Self-checking testbench for jacobi_five_point_sweep: streams grids through
// the block under random idling and back-pressure and checks every update.
// Depends on jfps_pkg and the jacobi_five_point_sweep RTL.
`timescale 1ns / 1ps

module jacobi_five_point_sweep_test;
  import jfps_pkg::*;

  localparam int DW = DATA_WIDTH_DEFAULT;
  localparam int LINE = MAX_LINE_DEFAULT;
  localparam int QUIET_LIMIT = 3000;
  localparam int HOLD_CYCLES = 400;
  localparam int RANDOM_ITEMS = 1600;
  localparam logic [CFG_INDEX_W-1:0] REG_UNMAPPED = 2'd3;

  typedef struct packed {
    logic signed [DW-1:0] value;
    logic [POS_OUT_W-1:0] row;
    logic [POS_OUT_W-1:0] col;
    logic                 closes_frame;
  } stencil_update_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic cell_valid = 1'b0;
  logic cell_stall;
  logic signed [DW-1:0] cell_value = '0;
  logic result_valid;
  logic result_stall = 1'b0;
  logic signed [DW-1:0] new_value;
  logic [POS_OUT_W-1:0] out_row;
  logic [POS_OUT_W-1:0] out_col;
  logic frame_end;

  jacobi_five_point_sweep dut (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .cell_valid(cell_valid), .cell_stall(cell_stall), .cell_value(cell_value),
    .result_valid(result_valid), .result_stall(result_stall), .new_value(new_value),
    .out_row(out_row), .out_col(out_col), .frame_end(frame_end)
  );

  always #5 clk = ~clk;

  logic signed [DW-1:0] pending_cells[$];
  stencil_update_t predicted_updates[$];
  logic signed [DW-1:0] col_before [LINE];
  logic signed [DW-1:0] col_centre [LINE];
  int row_pos = 0;
  int col_pos = 0;
  logic [SIZE_W-1:0] grid_interior = RESET_INTERIOR;
  logic [HALO_W-1:0] grid_halo = RESET_HALO;
  int mismatches = 0;
  int quiet_cycles = 0;
  bit steady = 1'b0;
  int choke_requests = 0;
  int choke_served = 0;
  int hold_left = 0;

  function automatic int grid_side();
    int side;
    side = int'(grid_interior) + 2 * int'(grid_halo);
    if (side > LINE) side = LINE;
    return side;
  endfunction

  function automatic void advance_stencil(input logic signed [DW-1:0] x);
    int side, r, c, h, n;
    logic signed [DW+1:0] total;
    logic signed [DW+1:0] quarter;
    stencil_update_t upd;
    h = int'(grid_halo);
    n = int'(grid_interior);
    side = grid_side();
    if (side == 0) return;
    r = (row_pos >= side) ? 0 : row_pos;
    c = (col_pos >= side) ? 0 : col_pos;
    if (c >= 2 && r >= 1 && r + 1 < side && c - 1 >= h && c - 1 < h + n &&
        r >= h && r < h + n) begin
      total = col_before[r-1] + col_centre[r+1] + col_before[r] + x;
      quarter = total >>> 2;
      upd.value = quarter[DW-1:0];
      upd.row = POS_OUT_W'(r - h);
      upd.col = POS_OUT_W'(c - 1 - h);
      upd.closes_frame = (r == h + n - 1) && (c - 1 == h + n - 1);
      predicted_updates.push_back(upd);
    end
    col_before[r] = col_centre[r];
    col_centre[r] = x;
    r++;
    if (r >= side) begin
      r = 0;
      c++;
      if (c >= side) c = 0;
    end
    row_pos = r;
    col_pos = c;
  endfunction

  function automatic logic signed [DW-1:0] pick_cell();
    case ($urandom_range(15))
      0: return {1'b0, {(DW-1){1'b1}}};
      1: return {1'b1, {(DW-1){1'b0}}};
      2: return '0;
      3: return '1;
      default: return DW'($urandom);
    endcase
  endfunction

  // Cell driver: hold a stalled transfer, otherwise offer the next cell or idle.
  always @(posedge clk) begin
    if (rst) begin
      cell_valid <= 1'b0;
    end else begin
      if (cell_valid && !cell_stall) advance_stencil(cell_value);
      if (!cell_valid || !cell_stall) begin
        if (pending_cells.size() != 0 && (steady || $urandom_range(99) >= 31)) begin
          cell_valid <= 1'b1;
          cell_value <= pending_cells.pop_front();
        end else begin
          cell_valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor and back-pressure.
  always @(posedge clk) begin
    stencil_update_t got, want;
    if (rst) begin
      result_stall <= 1'b0;
    end else begin
      if (result_valid && !result_stall) begin
        got = '{new_value, out_row, out_col, frame_end};
        if (predicted_updates.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected update: value %h row %0d col %0d end %b",
                     got.value, got.row, got.col, got.closes_frame);
        end else begin
          want = predicted_updates.pop_front();
          if (got.value !== want.value || got.row !== want.row || got.col !== want.col ||
              got.closes_frame !== want.closes_frame) begin
            mismatches++;
            if (mismatches <= 10)
              $display("update mismatch: expected value %h row %0d col %0d end %b, got value %h row %0d col %0d end %b",
                       want.value, want.row, want.col, want.closes_frame,
                       got.value, got.row, got.col, got.closes_frame);
          end
        end
      end
      if (hold_left > 0) begin
        hold_left--;
        result_stall <= 1'b1;
      end else if (choke_served != choke_requests) begin
        choke_served++;
        hold_left = HOLD_CYCLES;
        result_stall <= 1'b1;
      end else begin
        result_stall <= !steady && ($urandom_range(99) < 31);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (cell_valid && !cell_stall) || (result_valid && !result_stall) ||
        (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles == QUIET_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  task automatic wait_drained();
    do @(negedge clk);
    while (pending_cells.size() != 0 || cell_valid || predicted_updates.size() != 0);
  endtask

  task automatic write_register(input logic [CFG_INDEX_W-1:0] idx,
                                input logic [CFG_DATA_W-1:0] data);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk);
    while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      REG_INTERIOR_SIZE: grid_interior = data[SIZE_W-1:0];
      REG_HALO_WIDTH: grid_halo = data[HALO_W-1:0];
      default: ;
    endcase
    row_pos = 0;
    col_pos = 0;
  endtask

  task automatic configure(input int n, input int h);
    wait_drained();
    repeat (8) @(posedge clk);
    write_register(REG_INTERIOR_SIZE, CFG_DATA_W'(n));
    write_register(REG_HALO_WIDTH, {8'($urandom), 4'(h)});
  endtask

  task automatic load_random_cells(input int count);
    @(negedge clk);
    repeat (count) pending_cells.push_back(pick_cell());
  endtask

  initial begin
    logic signed [DW-1:0] small_vals[9];
    int side, frame, count, phase, random_items;
    small_vals = '{-1, -2, -3, 1, -5, 2, -7, -4, -1};
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // Smallest interior: extremes of the value range and floor rounding.
    configure(1, 1);
    @(negedge clk);
    repeat (9) pending_cells.push_back({1'b0, {(DW-1){1'b1}}});
    repeat (9) pending_cells.push_back({1'b1, {(DW-1){1'b0}}});
    foreach (small_vals[i]) pending_cells.push_back(small_vals[i]);

    // No halo, empty grid, no interior.
    configure(3, 0);
    load_random_cells(12);
    configure(0, 0);
    load_random_cells(6);
    configure(0, 3);
    load_random_cells(10);

    // Restart the frame midway through an unmapped register.
    configure(2, 1);
    load_random_cells(7);
    wait_drained();
    repeat (8) @(posedge clk);
    write_register(REG_UNMAPPED, CFG_DATA_W'($urandom));
    load_random_cells(20);

    phase = 0;
    random_items = 0;
    while (random_items < RANDOM_ITEMS) begin
      if ($urandom_range(9) == 0) begin
        wait_drained();
        repeat (8) @(posedge clk);
        write_register(REG_UNMAPPED, CFG_DATA_W'($urandom));
      end
      configure(($urandom_range(9) == 0) ? $urandom_range(0, 30) : $urandom_range(1, 10),
                ($urandom_range(9) == 0) ? 15 : $urandom_range(0, 3));
      side = grid_side();
      frame = side * side;
      if (frame == 0 || frame > 400)
        count = $urandom_range(1, 3 * side + 3);
      else
        case ($urandom_range(4))
          0: count = $urandom_range(1, frame + side);
          1: count = 2 * frame;
          default: count = frame;
        endcase
      @(negedge clk);
      steady = (phase == 4);
      if (phase == 2) choke_requests++;
      repeat (count) pending_cells.push_back(pick_cell());
      random_items += count;
      phase++;
      wait_drained();
      steady = 1'b0;
    end

    // Hold off results on a mid-size grid until the input stalls.
    configure(8, 1);
    @(negedge clk);
    choke_requests++;
    repeat (120) pending_cells.push_back(pick_cell());

    wait_drained();
    repeat (20) @(posedge clk);
    if (mismatches == 0 && predicted_updates.size() == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+src
src/jfps_pkg.sv
src/jfps_raster.sv
src/jfps_col_store.sv
src/jfps_out_queue.sv
src/jacobi_five_point_sweep.sv
tb/jacobi_five_point_sweep_test.sv
